### rtl/cfls_pkg.sv
// Package for the cube face Lambert shader: item types, fixed-point constants
// and the square root and division step functions.
// Depends on nothing; every other file but cfls_stream_if uses it.
`timescale 1ns / 1ps
`default_nettype none

package cfls_pkg;

    // Number of faces per item and the code of the last one (-z).
    localparam int unsigned FACE_COUNT = 6;
    localparam logic [2:0] FACE_LAST = 3'd5;

    // Fixed-point constants.
    localparam logic [14:0] Q15_MAX = 15'h7FFF;
    localparam logic [16:0] Q16_ONE = 17'h10000;
    localparam logic [8:0] AMBIENT_FULL = 9'd256;
    localparam logic [7:0] CHANNEL_MAX = 8'hFF;

    // Iteration structure of the normalizer pipeline.
    localparam int unsigned SQRT_STEPS = 16;
    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned STEPS_PER_STAGE = 2;
    localparam int unsigned SQRT_STAGES = SQRT_STEPS / STEPS_PER_STAGE;
    localparam int unsigned DIV_STAGES = DIV_STEPS / STEPS_PER_STAGE;

    // One input item.
    typedef struct packed {
        logic signed [15:0] light_x;
        logic signed [15:0] light_y;
        logic signed [15:0] light_z;
        logic [8:0] ambient_level;
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] base_alpha;
    } in_item_t;

    // One face result.
    typedef struct packed {
        logic [2:0] face_index;
        logic [7:0] shaded_red;
        logic [7:0] shaded_green;
        logic [7:0] shaded_blue;
        logic [7:0] shaded_alpha;
        logic last_face;
    } out_item_t;

    // A normalized item as it waits between front and back.
    typedef struct packed {
        logic [2:0][14:0] l_mag;
        logic [2:0] l_neg;
        logic [16:0] amb16;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } norm_item_t;

    // Working state of the bit-serial square root.
    typedef struct packed {
        logic [31:0] v;
        logic [31:0] root;
    } sqrt_state_t;

    // Result of one restoring division step.
    typedef struct packed {
        logic [15:0] r;
        logic q;
    } div_state_t;

    // One step of the integer square root with the given bit weight.
    function automatic sqrt_state_t sqrt_step(sqrt_state_t s, logic [31:0] bit_val);
        sqrt_state_t o;
        logic [31:0] trial;
        trial = s.root + bit_val;
        if (s.v >= trial)
        begin
            o.v = s.v - trial;
            o.root = (s.root >> 1) + bit_val;
        end
        else
        begin
            o.v = s.v;
            o.root = s.root >> 1;
        end
        return o;
    endfunction

    // One restoring division step; the remainder stays below len if it enters below len.
    function automatic div_state_t div_step(logic [15:0] r, logic b, logic [15:0] len);
        div_state_t o;
        logic [16:0] t;
        logic [16:0] diff;
        t = {r, b};
        diff = t - {1'b0, len};
        if (t >= {1'b0, len})
        begin
            o.r = diff[15:0];
            o.q = 1'b1;
        end
        else
        begin
            o.r = t[15:0];
            o.q = 1'b0;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

### rtl/cfls_stream_if.sv
// Valid/ready stream interface used for the input and result channels.
// The payload type is set per instance; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface cfls_stream_if #(
    parameter type payload_t = logic
);
    logic valid;
    logic ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/cfls_front.sv
// Front end: accepts items, sums the squares, takes the square root and
// divides each component by the length. Uses cfls_pkg and cfls_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module cfls_front (
    input wire logic clk,
    input wire logic rst_n,
    cfls_stream_if.sink light,
    output logic push,
    output cfls_pkg::norm_item_t push_data,
    input wire logic full
);

    localparam int unsigned SQ_BASE = 3;
    localparam int unsigned LEN_IDX = SQ_BASE + cfls_pkg::SQRT_STAGES;
    localparam int unsigned DIV_BASE = LEN_IDX + 1;
    localparam int unsigned LAST_IDX = DIV_BASE + cfls_pkg::DIV_STAGES;

    // Fields that travel along the pipeline unchanged.
    typedef struct packed {
        logic [2:0][15:0] mag;
        logic [2:0] neg;
        logic [16:0] amb16;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } side_t;

    logic en;
    logic [LAST_IDX:0] valid_reg;
    side_t side_reg [LAST_IDX];
    side_t side_in;
    logic [2:0][31:0] sq_reg;
    logic [31:0] sum_reg;
    cfls_pkg::sqrt_state_t sqst_reg [cfls_pkg::SQRT_STAGES];
    logic [15:0] len_reg;
    logic [15:0] dlen_reg [cfls_pkg::DIV_STAGES];
    logic [2:0][15:0] dr_reg [cfls_pkg::DIV_STAGES];
    logic [2:0][15:0] dq_reg [cfls_pkg::DIV_STAGES];
    cfls_pkg::norm_item_t norm_reg;

    // The whole pipeline moves while the last stage can hand off.
    assign en = !valid_reg[LAST_IDX] || !full;
    assign light.ready = en;
    assign push = valid_reg[LAST_IDX] && !full;
    assign push_data = norm_reg;

    // Magnitudes, signs and clamped ambient of the incoming item.
    always_comb
    begin
        logic signed [15:0] c [3];
        logic [8:0] amb;
        c[0] = light.payload.light_x;
        c[1] = light.payload.light_y;
        c[2] = light.payload.light_z;
        for (int j = 0; j < 3; j++)
        begin
            side_in.neg[j] = c[j][15];
            side_in.mag[j] = c[j][15] ? (16'd0 - c[j]) : c[j];
        end
        amb = (light.payload.ambient_level > cfls_pkg::AMBIENT_FULL)
            ? cfls_pkg::AMBIENT_FULL : light.payload.ambient_level;
        side_in.amb16 = {amb, 8'h00};
        side_in.red = light.payload.base_red;
        side_in.green = light.payload.base_green;
        side_in.blue = light.payload.base_blue;
        side_in.alpha = light.payload.base_alpha;
    end

    // Valid bits of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAST_IDX-1:0], light.valid};
        end
    end

    // Pass-through fields, squares and sum of squares.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < LAST_IDX; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j] <= side_reg[0].mag[j] * side_reg[0].mag[j];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    // Square root stages, two bit positions per stage.
    for (genvar k = 0; k < cfls_pkg::SQRT_STAGES; k++)
    begin : g_sqrt
        cfls_pkg::sqrt_state_t s_in;
        cfls_pkg::sqrt_state_t s_mid;
        cfls_pkg::sqrt_state_t s_out;
        always_comb
        begin
            if (k == 0)
            begin
                s_in.v = sum_reg;
                s_in.root = '0;
            end
            else
            begin
                s_in = sqst_reg[(k == 0) ? 0 : k-1];
            end
            s_mid = cfls_pkg::sqrt_step(s_in, 32'h1 << (30 - 4*k));
            s_out = cfls_pkg::sqrt_step(s_mid, 32'h1 << (28 - 4*k));
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sqst_reg[k] <= s_out;
            end
        end
    end

    // Length, with a zero vector taken as length one.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            len_reg <= (sqst_reg[cfls_pkg::SQRT_STAGES-1].root[15:0] == 16'd0)
                ? 16'd1 : sqst_reg[cfls_pkg::SQRT_STAGES-1].root[15:0];
        end
    end

    // Division stages: (mag << 15) / len, two quotient bits per stage per lane.
    for (genvar k = 0; k < cfls_pkg::DIV_STAGES; k++)
    begin : g_div
        logic [15:0] len_in;
        logic [2:0][15:0] r_next;
        logic [2:0][15:0] q_next;
        always_comb
        begin
            cfls_pkg::div_state_t a;
            cfls_pkg::div_state_t b;
            logic [15:0] r_in;
            logic [15:0] q_in;
            logic first_bit;
            len_in = (k == 0) ? len_reg : dlen_reg[(k == 0) ? 0 : k-1];
            for (int j = 0; j < 3; j++)
            begin
                if (k == 0)
                begin
                    r_in = {1'b0, side_reg[DIV_BASE+k-1].mag[j][15:1]};
                    q_in = '0;
                    first_bit = side_reg[DIV_BASE+k-1].mag[j][0];
                end
                else
                begin
                    r_in = dr_reg[(k == 0) ? 0 : k-1][j];
                    q_in = dq_reg[(k == 0) ? 0 : k-1][j];
                    first_bit = 1'b0;
                end
                a = cfls_pkg::div_step(r_in, first_bit, len_in);
                b = cfls_pkg::div_step(a.r, 1'b0, len_in);
                r_next[j] = b.r;
                q_next[j] = {q_in[13:0], a.q, b.q};
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dlen_reg[k] <= len_in;
                dr_reg[k] <= r_next;
                dq_reg[k] <= q_next;
            end
        end
    end

    // Clamp the quotients to Q0.15 and form the queued item.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
            begin
                norm_reg.l_mag[j] <= dq_reg[cfls_pkg::DIV_STAGES-1][j][15]
                    ? cfls_pkg::Q15_MAX : dq_reg[cfls_pkg::DIV_STAGES-1][j][14:0];
            end
            norm_reg.l_neg <= side_reg[LAST_IDX-1].neg;
            norm_reg.amb16 <= side_reg[LAST_IDX-1].amb16;
            norm_reg.red <= side_reg[LAST_IDX-1].red;
            norm_reg.green <= side_reg[LAST_IDX-1].green;
            norm_reg.blue <= side_reg[LAST_IDX-1].blue;
            norm_reg.alpha <= side_reg[LAST_IDX-1].alpha;
        end
    end

endmodule

`default_nettype wire

### rtl/cfls_queue.sv
// Short queue of normalized items between front and back.
// Uses cfls_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module cfls_queue #(
    parameter int unsigned DEPTH = 2
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic push,
    input wire cfls_pkg::norm_item_t push_data,
    output logic full,
    input wire logic pop,
    output logic avail,
    output cfls_pkg::norm_item_t pop_data
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cfls_pkg::norm_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full = (count_reg == CNT_FULL);
    assign avail = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/cfls_back.sv
// Back end: walks the six faces of each queued item, computes the shade and
// scales the color channels. Uses cfls_pkg and cfls_stream_if.
`timescale 1ns / 1ps
`default_nettype none

module cfls_back (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic avail,
    input wire cfls_pkg::norm_item_t pop_data,
    output logic pop,
    cfls_stream_if.source faces
);

    logic en;
    logic take;
    logic [2:0] face_reg;

    logic b1_valid_reg;
    logic [2:0] b1_face_reg;
    logic [14:0] b1_d_reg;
    logic [16:0] b1_amb16_reg;
    logic [16:0] b1_oneminus_reg;
    logic [7:0] b1_red_reg;
    logic [7:0] b1_green_reg;
    logic [7:0] b1_blue_reg;
    logic [7:0] b1_alpha_reg;

    logic b2_valid_reg;
    logic [2:0] b2_face_reg;
    logic [16:0] b2_shade_reg;
    logic [7:0] b2_red_reg;
    logic [7:0] b2_green_reg;
    logic [7:0] b2_blue_reg;
    logic [7:0] b2_alpha_reg;

    logic out_valid_reg;
    cfls_pkg::out_item_t out_reg;

    logic [1:0] axis;
    logic [14:0] d_next;
    logic [31:0] diffuse;
    logic [16:0] shade_next;

    // The back pipeline moves while the output register can be refilled.
    assign en = !out_valid_reg || faces.ready;
    assign take = en && avail;
    assign pop = take && (face_reg == cfls_pkg::FACE_LAST);
    assign faces.valid = out_valid_reg;
    assign faces.payload = out_reg;

    // Clamped n . L for the current face.
    always_comb
    begin
        axis = face_reg[2:1];
        if (face_reg[0] == pop_data.l_neg[axis])
        begin
            d_next = pop_data.l_mag[axis];
        end
        else
        begin
            d_next = '0;
        end
    end

    // Shade in Q1.16 from the registered ambient and n . L terms.
    always_comb
    begin
        diffuse = b1_oneminus_reg * b1_d_reg;
        shade_next = b1_amb16_reg + diffuse[31:15];
    end

    // Face counter and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            face_reg <= '0;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= avail;
            b2_valid_reg <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
            if (avail)
            begin
                face_reg <= (face_reg == cfls_pkg::FACE_LAST) ? '0 : face_reg + 1'b1;
            end
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        logic [24:0] pr;
        logic [24:0] pg;
        logic [24:0] pb;
        if (en)
        begin
            b1_face_reg <= face_reg;
            b1_d_reg <= d_next;
            b1_amb16_reg <= pop_data.amb16;
            b1_oneminus_reg <= cfls_pkg::Q16_ONE - pop_data.amb16;
            b1_red_reg <= pop_data.red;
            b1_green_reg <= pop_data.green;
            b1_blue_reg <= pop_data.blue;
            b1_alpha_reg <= pop_data.alpha;

            b2_face_reg <= b1_face_reg;
            b2_shade_reg <= shade_next;
            b2_red_reg <= b1_red_reg;
            b2_green_reg <= b1_green_reg;
            b2_blue_reg <= b1_blue_reg;
            b2_alpha_reg <= b1_alpha_reg;

            pr = b2_red_reg * b2_shade_reg;
            pg = b2_green_reg * b2_shade_reg;
            pb = b2_blue_reg * b2_shade_reg;
            out_reg.face_index <= b2_face_reg;
            out_reg.shaded_red <= pr[24] ? cfls_pkg::CHANNEL_MAX : pr[23:16];
            out_reg.shaded_green <= pg[24] ? cfls_pkg::CHANNEL_MAX : pg[23:16];
            out_reg.shaded_blue <= pb[24] ? cfls_pkg::CHANNEL_MAX : pb[23:16];
            out_reg.shaded_alpha <= b2_alpha_reg;
            out_reg.last_face <= (b2_face_reg == cfls_pkg::FACE_LAST);
        end
    end

endmodule

`default_nettype wire

### rtl/cube_face_lambert_shader.sv
// Cube face Lambert shader, top level. An item passes the normalizer, queue
// and back-end registers before its first face result appears; the remaining
// five follow one per cycle while the receiver is ready. A new item is taken
// every cycle while the normalizer can advance, that is while its last stage
// is empty or the queue has room; sustained throughput is set by the
// one-face-per-cycle back end. Reset clears valid bits, pointers and the face
// counter; there is no clearing pass and items are taken right after reset.
`timescale 1ns / 1ps
`default_nettype none

module cube_face_lambert_shader #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input wire logic clk,
    input wire logic rst_n,
    cfls_stream_if.sink light,
    cfls_stream_if.source faces
);

    logic push;
    logic full;
    logic pop;
    logic avail;
    cfls_pkg::norm_item_t push_data;
    cfls_pkg::norm_item_t pop_data;

    // Normalizer pipeline.
    cfls_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .light(light),
        .push(push),
        .push_data(push_data),
        .full(full)
    );

    // Decoupling queue.
    cfls_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_data(push_data),
        .full(full),
        .pop(pop),
        .avail(avail),
        .pop_data(pop_data)
    );

    // Face shading.
    cfls_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .avail(avail),
        .pop_data(pop_data),
        .pop(pop),
        .faces(faces)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
// Testbench for the cube face Lambert shader: drives light/color items, predicts
// the six shaded faces per item, and compares every face transfer in order.
// Depends on cfls_pkg, cfls_stream_if and the cube_face_lambert_shader RTL.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cfls_stream_if #(.payload_t(cfls_pkg::in_item_t)) light_bus ();
    cfls_stream_if #(.payload_t(cfls_pkg::out_item_t)) face_bus ();

    cube_face_lambert_shader dut (
        .clk(clk),
        .rst_n(rst_n),
        .light(light_bus.sink),
        .faces(face_bus.source)
    );

    always #4 clk = ~clk;

    cfls_pkg::out_item_t expected_faces[$];
    int mismatches = 0;
    int faces_seen = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    bit hold_off = 1'b0;

    // Integer square root, bit-serial, 16 iterations.
    function automatic logic [31:0] root_of(logic [31:0] v);
        logic [31:0] root;
        logic [31:0] b;
        root = '0;
        b = 32'h4000_0000;
        for (int i = 0; i < 16; i++)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // Signed Q1.15 light component, saturated to magnitude 32767.
    function automatic int unit_component(logic signed [15:0] c, logic [31:0] len);
        longint m;
        longint q;
        m = (c < 0) ? -longint'(c) : longint'(c);
        q = (m * 32768) / len;
        if (q > 32767)
            q = 32767;
        return (c < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic logic [7:0] lit_channel(logic [7:0] b, longint shade);
        longint v;
        v = (longint'(b) * shade) >> 16;
        return (v > 255) ? 8'hFF : v[7:0];
    endfunction

    // Work out all six face results of one item and queue them.
    task automatic predict_faces(cfls_pkg::in_item_t it);
        logic [31:0] sum;
        logic [31:0] len;
        int lc[3];
        int ndl;
        longint amb16;
        longint d;
        longint shade;
        cfls_pkg::out_item_t f;
        sum = 32'(longint'(it.light_x) * it.light_x + longint'(it.light_y) * it.light_y
                  + longint'(it.light_z) * it.light_z);
        len = root_of(sum);
        if (len == 0)
            len = 1;
        lc[0] = unit_component(it.light_x, len);
        lc[1] = unit_component(it.light_y, len);
        lc[2] = unit_component(it.light_z, len);
        amb16 = (it.ambient_level > 256) ? 256 * 256 : longint'(it.ambient_level) * 256;
        for (int k = 0; k < cfls_pkg::FACE_COUNT; k++)
        begin
            ndl = (k % 2) ? -lc[k / 2] : lc[k / 2];
            d = (ndl > 0) ? ndl : 0;
            shade = amb16 + (((65536 - amb16) * 2 * d) >> 16);
            f.face_index = 3'(k);
            f.shaded_red = lit_channel(it.base_red, shade);
            f.shaded_green = lit_channel(it.base_green, shade);
            f.shaded_blue = lit_channel(it.base_blue, shade);
            f.shaded_alpha = it.base_alpha;
            f.last_face = (3'(k) == cfls_pkg::FACE_LAST);
            expected_faces.push_back(f);
        end
    endtask

    // Send one item; random idle bursts before it when enabled.
    task automatic send_item(cfls_pkg::in_item_t it);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            light_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        light_bus.valid <= 1'b1;
        light_bus.payload <= it;
        @(posedge clk);
        while (!light_bus.ready)
            @(posedge clk);
        predict_faces(it);
        items_sent++;
    endtask

    // Drop valid and wait for the next clock edge before anything else drives it.
    task automatic go_quiet();
        light_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic cfls_pkg::in_item_t make_item(int x, int y, int z, int amb);
        cfls_pkg::in_item_t it;
        it.light_x = 16'(x);
        it.light_y = 16'(y);
        it.light_z = 16'(z);
        it.ambient_level = 9'(amb);
        it.base_red = 8'($urandom);
        it.base_green = 8'($urandom);
        it.base_blue = 8'($urandom);
        it.base_alpha = 8'($urandom);
        return it;
    endfunction

    function automatic cfls_pkg::in_item_t random_item();
        cfls_pkg::in_item_t it;
        it = make_item($urandom, $urandom, $urandom, $urandom_range(0, 511));
        case ($urandom_range(0, 5))
            0: it.ambient_level = 9'($urandom_range(0, 256));
            1: it = make_item($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                              $urandom_range(0, 15) - 8, $urandom_range(0, 256));
            2: it.light_y = '0;
            default: ;
        endcase
        return it;
    endfunction

    // Receiver: random stalls, optional long hold-off; checks each transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
            face_bus.ready <= 1'b0;
        else
        begin
            if (face_bus.valid && face_bus.ready)
            begin
                faces_seen++;
                if (expected_faces.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected face transfer: %p", face_bus.payload);
                end
                else
                begin
                    cfls_pkg::out_item_t e;
                    e = expected_faces.pop_front();
                    if (face_bus.payload !== e)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Face mismatch: expected %p, got %p", e,
                                     face_bus.payload);
                    end
                end
            end
            if (hold_off)
                face_bus.ready <= 1'b0;
            else if (recv_gaps)
                face_bus.ready <= ($urandom_range(0, 3) != 0);
            else
                face_bus.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((light_bus.valid && light_bus.ready) || (face_bus.valid && face_bus.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > 5000)
        begin
            $display("FAIL cube_face_lambert_shader");
            $finish;
        end
    end

    // Extremes of the light and ambient fields, zero vector, unit vectors of both signs.
    task automatic test_directed();
        int axis_vals[6] = '{32767, -32768, 1, -1, 100, -100};
        for (int a = 0; a < 6; a++)
        begin
            send_item(make_item(axis_vals[a], 0, 0, 0));
            send_item(make_item(0, axis_vals[a], 0, 64));
            send_item(make_item(0, 0, axis_vals[a], 128));
        end
        send_item(make_item(0, 0, 0, 0));
        send_item(make_item(0, 0, 0, 200));
        send_item(make_item(-32768, -32768, -32768, 256));
        send_item(make_item(32767, 32767, 32767, 511));
        send_item(make_item(32767, -32768, 12345, 257));
        send_item(make_item(-1, -1, -1, 255));
        go_quiet();
    endtask

    // Sender keeps offering while the receiver holds off, so the block fills.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
            repeat (40) send_item(random_item());
        join
        go_quiet();
    endtask

    task automatic test_random(int n, bit gaps);
        send_gaps = gaps;
        recv_gaps = gaps;
        repeat (n) send_item(random_item());
        go_quiet();
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_faces.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        light_bus.valid <= 1'b0;
        light_bus.payload <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(250, 1'b1);
        test_random(56, 1'b0);
        drain();
        $display("Sent %0d light items, checked %0d face results, %0d mismatches.",
                 items_sent, faces_seen, mismatches);
        if (mismatches == 0 && expected_faces.size() == 0)
            $display("PASS cube_face_lambert_shader");
        else
            $display("FAIL cube_face_lambert_shader");
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
rtl/cfls_pkg.sv
rtl/cfls_stream_if.sv
rtl/cfls_front.sv
rtl/cfls_queue.sv
rtl/cfls_back.sv
rtl/cube_face_lambert_shader.sv
tb/tb_top.sv
